>>> design/mbc1_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbc1_pkg
// Shared widths, constants and codes of the MBC1 bank controller.
// ----------------------------------------------------------------------------
package mbc1_pkg;

  localparam int ROM_ADDR_BITS = 21;
  localparam int RAM_ADDR_BITS = 15;
  localparam int ROM_DEPTH     = 1 << ROM_ADDR_BITS;
  localparam int RAM_DEPTH     = 1 << RAM_ADDR_BITS;

  localparam int ROM_LOG2_W = 5;
  localparam int RAM_LOG2_W = 4;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_IDX_W  = 1;

  typedef logic [1:0]               mode_t;
  typedef logic [15:0]              bus_addr_t;
  typedef logic [7:0]               byte_t;
  typedef logic [ROM_ADDR_BITS-1:0] rom_addr_t;
  typedef logic [RAM_ADDR_BITS-1:0] ram_addr_t;

  // Item modes
  localparam mode_t MODE_READ  = 2'd0;
  localparam mode_t MODE_WRITE = 2'd1;
  localparam mode_t MODE_LOAD  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_SIZE = 1'd1;

  localparam logic [ROM_LOG2_W-1:0] ROM_SIZE_RESET = 5'd15;
  localparam logic [RAM_LOG2_W-1:0] RAM_SIZE_RESET = 4'd0;

  // Bus address regions by address bits 15:13
  localparam logic [2:0] REG_RAM_EN   = 3'b000;
  localparam logic [2:0] REG_ROM_BANK = 3'b001;
  localparam logic [2:0] REG_UPPER    = 3'b010;
  localparam logic [2:0] REG_MODE     = 3'b011;
  localparam logic [2:0] RAM_WINDOW   = 3'b101;

  localparam logic [3:0] RAM_EN_KEY = 4'hA;
  localparam byte_t      OPEN_BUS   = 8'hFF;

endpackage : mbc1_pkg
`default_nettype wire

>>> design/mbc1_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbc1_if
// Valid/ready channels of the bank controller: bus requests and read data.
// ----------------------------------------------------------------------------
interface mbc1_req_if;
  import mbc1_pkg::*;

  logic      valid;
  logic      ready;
  mode_t     mode;
  bus_addr_t address;
  byte_t     data;
  rom_addr_t rom_offset;

  modport source (output valid, output mode, output address, output data,
                  output rom_offset, input ready);
  modport sink   (input valid, input mode, input address, input data,
                  input rom_offset, output ready);
endinterface : mbc1_req_if

interface mbc1_rsp_if;
  import mbc1_pkg::*;

  logic  valid;
  logic  ready;
  byte_t read_data;

  modport source (output valid, output read_data, input ready);
  modport sink   (input valid, input read_data, output ready);
endinterface : mbc1_rsp_if
`default_nettype wire

>>> design/mbc1_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbc1_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mbc1_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data between reads
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : mbc1_ram
`default_nettype wire

>>> design/mbc1_bank_controller_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbc1_bank_controller_top
// MBC1 cartridge mapper: bank registers, ROM store and cartridge RAM.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload                             Transfer
// req      in   mode, address, data, rom_offset     valid & ready
// rsp      out  read_data                           valid & ready
// cfg      in   cfg_we, cfg_index, cfg_data         cfg_we
//
// One request per cycle. A read returns its byte through the memory read
// register and then the output register; writes and loads give none.
// After reset the RAM is zeroed one byte a cycle, with req.ready low until all
// 32768 bytes are clear. Configuration writes are taken at any time.
// A read stuck behind a stalled result holds req.ready low.
// ----------------------------------------------------------------------------
module mbc1_bank_controller_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  mbc1_req_if.sink                            req,
  mbc1_rsp_if.source                          rsp,
  input  wire logic                           cfg_we,
  input  wire logic [mbc1_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mbc1_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mbc1_pkg::*;

  typedef enum logic [1:0] {SRC_ROM, SRC_RAM, SRC_OPEN} src_t;

  // Configuration and bank registers
  logic [ROM_LOG2_W-1:0] rom_size_log2;
  logic [RAM_LOG2_W-1:0] ram_size_log2;
  logic [4:0]            rom_bank_low;
  logic [1:0]            upper_bank;
  logic                  ram_enable;
  logic                  bank_mode;

  // Clearing pass
  logic      clearing;
  ram_addr_t clr_addr;

  // Read pipeline
  logic  pend;
  src_t  pend_src;
  logic  out_valid;
  byte_t out_data;

  logic accept, is_read, is_write, is_load, pend_move;
  logic ram_hit, ram_on;
  logic [ROM_LOG2_W-1:0] rom_bits;
  logic [RAM_LOG2_W-1:0] ram_bits;
  rom_addr_t rom_mask, rom_raw, rom_raddr;
  ram_addr_t ram_mask, ram_off;
  logic [1:0] ram_bank;
  logic [6:0] rom_bank;
  logic [4:0] low_in;
  src_t       src_next;

  logic      rom_we, rom_re, ram_we, ram_re;
  ram_addr_t ram_waddr;
  byte_t     ram_wdata, rom_rdata, ram_rdata;

  assign pend_move = pend && (!out_valid || rsp.ready);
  assign req.ready = !clearing && (!pend || !out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign is_read   = accept && (req.mode == MODE_READ);
  assign is_write  = accept && (req.mode == MODE_WRITE);
  assign is_load   = accept && (req.mode == MODE_LOAD);

  // Size masks, sizes above the store clamp to the store
  always_comb begin
    rom_bits = (rom_size_log2 > ROM_LOG2_W'(ROM_ADDR_BITS)) ?
               ROM_LOG2_W'(ROM_ADDR_BITS) : rom_size_log2;
    ram_bits = (ram_size_log2 > RAM_LOG2_W'(RAM_ADDR_BITS)) ?
               RAM_LOG2_W'(RAM_ADDR_BITS) : ram_size_log2;
    rom_mask = ~({ROM_ADDR_BITS{1'b1}} << rom_bits);
    ram_mask = ~({RAM_ADDR_BITS{1'b1}} << ram_bits);
  end

  // Address mapping
  always_comb begin
    if (req.address[14]) begin
      rom_bank = {upper_bank, rom_bank_low};
    end else begin
      rom_bank = bank_mode ? {upper_bank, 5'd0} : 7'd0;
    end
    rom_raw   = {rom_bank, req.address[13:0]};
    rom_raddr = rom_raw & rom_mask;
    ram_bank  = bank_mode ? upper_bank : 2'd0;
    ram_off   = {ram_bank, req.address[12:0]} & ram_mask;
    ram_hit   = (req.address[15:13] == RAM_WINDOW);
    ram_on    = ram_enable && (ram_size_log2 != '0);
    low_in    = req.data[4:0];
  end

  always_comb begin
    if (!req.address[15]) begin
      src_next = SRC_ROM;
    end else if (ram_hit && ram_on) begin
      src_next = SRC_RAM;
    end else begin
      src_next = SRC_OPEN;
    end
  end

  assign rom_we    = is_load;
  assign rom_re    = is_read && (src_next == SRC_ROM);
  assign ram_re    = is_read && (src_next == SRC_RAM);
  assign ram_we    = clearing || (is_write && ram_hit && ram_on);
  assign ram_waddr = clearing ? clr_addr : ram_off;
  assign ram_wdata = clearing ? '0 : req.data;

  mbc1_ram #(.WIDTH(8), .DEPTH(ROM_DEPTH)) u_rom (
    .clk   (clk),
    .we    (rom_we),
    .waddr (req.rom_offset),
    .wdata (req.data),
    .re    (rom_re),
    .raddr (rom_raddr),
    .rdata (rom_rdata)
  );

  mbc1_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_cram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_off),
    .rdata (ram_rdata)
  );

  // Configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_size_log2 <= ROM_SIZE_RESET;
      ram_size_log2 <= RAM_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROM_SIZE: rom_size_log2 <= cfg_data;
        CFG_RAM_SIZE: ram_size_log2 <= cfg_data[RAM_LOG2_W-1:0];
        default: ;
      endcase
    end
  end

  // Bank registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank_low <= 5'd1;
      upper_bank   <= 2'd0;
      ram_enable   <= 1'b0;
      bank_mode    <= 1'b0;
    end else if (is_write) begin
      case (req.address[15:13])
        REG_RAM_EN:   ram_enable <= (req.data[3:0] == RAM_EN_KEY);
        REG_ROM_BANK: rom_bank_low <= (low_in == '0) ? 5'd1 : low_in;
        REG_UPPER:    upper_bank <= req.data[1:0];
        REG_MODE:     bank_mode <= req.data[0];
        default: ;
      endcase
    end
  end

  // RAM clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  // Read pipeline: memory stage, then output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (is_read) begin
        pend <= 1'b1;
      end else if (pend_move) begin
        pend <= 1'b0;
      end
      if (pend_move) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_read) begin
      pend_src <= src_next;
    end
    if (pend_move) begin
      case (pend_src)
        SRC_ROM: out_data <= rom_rdata;
        SRC_RAM: out_data <= ram_rdata;
        default: out_data <= OPEN_BUS;
      endcase
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_data;

endmodule : mbc1_bank_controller_top
`default_nettype wire

>>> tb/mbc1_bank_controller_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mbc1_bank_controller_top_tb
// Self-checking bench for the MBC1 bank controller. A short table of bus
// accesses pins down open bus, bank zero forcing, mode 1 banking and RAM
// gating. Random accesses then run under a series of ROM/RAM size settings.
// Read data is checked against a bank-register and memory-image predictor.
// ----------------------------------------------------------------------------
module mbc1_bank_controller_top_tb;
  import mbc1_pkg::*;

  localparam int unsigned HALF_PERIOD    = 4;
  localparam int unsigned DRAIN_CYCLES   = 6;
  // The RAM clearing pass after reset alone keeps the bus quiet while it zeroes all 32768 RAM bytes.
  localparam int unsigned WATCHDOG_LIMIT = 100_000;
  localparam int unsigned N_PHASES       = 8;
  localparam int unsigned PHASE_ITEMS    = 232;

  // Requests the block must drop without effect
  localparam mode_t MODE_NOP = 2'd3;

  // Bank register select, address bits 14:13 below 0x8000
  localparam logic [1:0] SEL_RAM_EN   = 2'd0;
  localparam logic [1:0] SEL_ROM_BANK = 2'd1;
  localparam logic [1:0] SEL_UPPER    = 2'd2;
  localparam logic [1:0] SEL_MODE     = 2'd3;

  typedef struct packed {
    mode_t     mode;
    bus_addr_t address;
    byte_t     data;
    rom_addr_t rom_offset;
  } bus_req_t;

  typedef enum logic {ROW_ACCESS, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    bus_req_t                 req;
    logic                     typed;
    byte_t                    rd;
    logic [CFG_IDX_W-1:0]     cfg_idx;
    logic [CFG_DATA_W-1:0]    cfg_val;
  } step_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mbc1_req_if req ();
  mbc1_rsp_if rsp ();

  mbc1_bank_controller_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Predicted cartridge state
  logic [ROM_LOG2_W-1:0] rom_size_cfg = ROM_SIZE_RESET;
  logic [RAM_LOG2_W-1:0] ram_size_cfg = RAM_SIZE_RESET;
  logic [4:0]            rom_bank_sel = 5'd1;
  logic [1:0]            upper_bits   = 2'd0;
  logic                  ram_open     = 1'b0;
  logic                  banking_mode = 1'b0;
  byte_t                 rom_img [int unsigned];
  byte_t                 ram_img [RAM_DEPTH];

  byte_t       read_data_q [$];
  int unsigned n_reads, n_writes, n_loads, n_ignored, n_checked, mismatches;
  int unsigned burst_left, gap_len, idle_cycles;

  function automatic int unsigned rom_index(bus_addr_t a);
    int unsigned bank, span;
    span = (rom_size_cfg > ROM_ADDR_BITS) ? ROM_ADDR_BITS : rom_size_cfg;
    if (!a[14]) begin
      bank = banking_mode ? {upper_bits, 5'd0} : 0;
    end else begin
      bank = {upper_bits, rom_bank_sel};
    end
    return ((bank << 14) | a[13:0]) & ((1 << span) - 1);
  endfunction

  function automatic int unsigned ram_index(bus_addr_t a);
    int unsigned bank, span;
    span = (ram_size_cfg > RAM_ADDR_BITS) ? RAM_ADDR_BITS : ram_size_cfg;
    bank = banking_mode ? upper_bits : 0;
    return ((bank << 13) | a[12:0]) & ((1 << span) - 1);
  endfunction

  // Advance the cartridge state by one access; returns 1 when a byte comes back.
  function automatic bit predict_access(input bus_req_t it, output byte_t rd);
    logic ram_live;
    ram_live = ram_open && (ram_size_cfg != 0) && (it.address[15:13] == RAM_WINDOW);
    rd = OPEN_BUS;
    predict_access = 1'b0;
    case (it.mode)
      MODE_READ: begin
        predict_access = 1'b1;
        if (!it.address[15]) begin
          rd = rom_img[rom_index(it.address)];
        end else if (ram_live) begin
          rd = ram_img[ram_index(it.address)];
        end
      end
      MODE_WRITE: begin
        if (!it.address[15]) begin
          case (it.address[14:13])
            SEL_RAM_EN:   ram_open = (it.data[3:0] == RAM_EN_KEY);
            SEL_ROM_BANK: rom_bank_sel = (it.data[4:0] == 5'd0) ? 5'd1 : it.data[4:0];
            SEL_UPPER:    upper_bits = it.data[1:0];
            SEL_MODE:     banking_mode = it.data[0];
            default: ;
          endcase
        end else if (ram_live) begin
          ram_img[ram_index(it.address)] = it.data;
        end
      end
      MODE_LOAD: rom_img[it.rom_offset] = it.data;
      default: ;
    endcase
  endfunction

  function automatic step_row_t access_row(mode_t m, bus_addr_t a, byte_t d, rom_addr_t off);
    step_row_t r;
    r = '0;
    r.kind = ROW_ACCESS;
    r.req  = '{mode: m, address: a, data: d, rom_offset: off};
    return r;
  endfunction

  function automatic step_row_t read_row(bus_addr_t a, byte_t rd);
    step_row_t r;
    r = access_row(MODE_READ, a, 8'h00, '0);
    r.typed = 1'b1;
    r.rd    = rd;
    return r;
  endfunction

  function automatic step_row_t cfg_row(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] val);
    step_row_t r;
    r = '0;
    r.kind    = ROW_CFG;
    r.cfg_idx = idx;
    r.cfg_val = val;
    return r;
  endfunction

  function automatic bus_req_t random_access();
    bus_req_t    it;
    int unsigned pick;
    it.mode       = MODE_READ;
    it.address    = 16'($urandom);
    it.data       = 8'($urandom);
    it.rom_offset = ROM_ADDR_BITS'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      // ROM read, often in a narrow window so loaded bytes get read again
      it.address[15] = 1'b0;
      if ($urandom_range(0, 1) == 0) it.address[13:5] = '0;
    end else if (pick < 55) begin
      it.mode = (pick < 40) ? MODE_READ : MODE_WRITE;
      it.address[15:13] = RAM_WINDOW;
      if ($urandom_range(0, 1) == 0) it.address[12:0] = 13'($urandom_range(0, 31));
    end else if (pick < 70) begin
      it.mode = MODE_WRITE;
      it.address[15] = 1'b0;
      if (it.address[14:13] == SEL_RAM_EN && $urandom_range(0, 3) != 0) begin
        it.data[3:0] = RAM_EN_KEY;
      end
    end else if (pick < 80) begin
      it.mode = MODE_LOAD;
    end else if (pick < 90) begin
      it.mode = $urandom_range(0, 1) ? MODE_READ : MODE_WRITE;
      if ($urandom_range(0, 1) == 0) begin
        it.address[15:13] = 3'b100;
      end else begin
        it.address[15:14] = 2'b11;
      end
    end else if (pick < 95) begin
      it.mode = MODE_NOP;
    end else begin
      it.mode = mode_t'($urandom);
    end
    return it;
  endfunction

  // Present one request, hold it until the transfer, then apply the sender's gaps.
  task automatic issue(input bus_req_t it, input bit typed, input byte_t rd);
    byte_t want;
    req.valid      <= 1'b1;
    req.mode       <= it.mode;
    req.address    <= it.address;
    req.data       <= it.data;
    req.rom_offset <= it.rom_offset;
    do @(posedge clk); while (!req.ready);
    if (predict_access(it, want)) read_data_q.push_back(typed ? rd : want);
    case (it.mode)
      MODE_READ:  n_reads++;
      MODE_WRITE: n_writes++;
      MODE_LOAD:  n_loads++;
      default:    n_ignored++;
    endcase
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        burst_left = 100;
        gap_len    = 0;
      end else begin
        burst_left = $urandom_range(1, 24);
        gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      if (gap_len > 0) begin
        req.valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
  endtask

  // Hold off until every read has returned and the pipeline has drained.
  task automatic wait_idle();
    req.valid <= 1'b0;
    while (read_data_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ROM_SIZE) begin
      rom_size_cfg = val;
    end else begin
      ram_size_cfg = val[RAM_LOG2_W-1:0];
    end
    @(posedge clk);
  endtask

  initial begin : rsp_stall
    logic [15:0] stall_pattern;
    int unsigned hold;
    rsp.ready     = 1'b0;
    stall_pattern = '1;
    hold          = 0;
    forever begin
      @(posedge clk);
      if (hold == 0) begin
        hold          = $urandom_range(16, 96);
        stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        if (stall_pattern == 16'h0000) stall_pattern = 16'h0001;
      end
      rsp.ready     <= stall_pattern[0];
      stall_pattern  = {stall_pattern[0], stall_pattern[15:1]};
      hold--;
    end
  end

  always @(posedge clk) begin : read_check
    byte_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (read_data_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: read_data %02h with no read outstanding", $realtime, rsp.read_data);
        end
      end else begin
        want = read_data_q.pop_front();
        n_checked++;
        if (rsp.read_data !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: read_data expected %02h, got %02h", $realtime, want,
                     rsp.read_data);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    step_row_t   plan [$];
    bus_req_t    it, fill;
    int unsigned base, phase, rom_sz, ram_sz;
    rst            = 1'b1;
    req.valid      = 1'b0;
    req.mode       = MODE_READ;
    req.address    = '0;
    req.data       = '0;
    req.rom_offset = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_ROM_SIZE;
    cfg_data       = '0;
    burst_left     = 1;
    gap_len        = 0;
    foreach (ram_img[i]) ram_img[i] = 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    plan.push_back(cfg_row(CFG_ROM_SIZE, 5'd21));
    plan.push_back(cfg_row(CFG_RAM_SIZE, 5'd15));
    // open bus: RAM still disabled, top of the map unmapped
    plan.push_back(read_row(16'hA000, OPEN_BUS));
    plan.push_back(read_row(16'hFFFF, OPEN_BUS));
    // dropped request must not enable RAM
    plan.push_back(access_row(MODE_NOP, 16'h0000, 8'h0A, 21'h1FFFFF));
    plan.push_back(read_row(16'hA000, OPEN_BUS));
    plan.push_back(access_row(MODE_LOAD, 16'h0000, 8'h5A, 21'h000000));
    plan.push_back(access_row(MODE_LOAD, 16'h0000, 8'hA5, 21'h1FFFFF));
    plan.push_back(read_row(16'h0000, 8'h5A));
    // bank 0 written reads as bank 1
    plan.push_back(access_row(MODE_WRITE, 16'h2000, 8'h00, '0));
    plan.push_back(access_row(MODE_LOAD, 16'h0000, 8'h81, 21'h004000));
    plan.push_back(read_row(16'h4000, 8'h81));
    plan.push_back(access_row(MODE_WRITE, 16'h4000, 8'hFF, '0));
    plan.push_back(access_row(MODE_WRITE, 16'h2000, 8'hFF, '0));
    plan.push_back(read_row(16'h7FFF, 8'hA5));
    // mode 1: upper bits reach the fixed bank and select the RAM bank
    plan.push_back(access_row(MODE_WRITE, 16'h6000, 8'h01, '0));
    plan.push_back(access_row(MODE_LOAD, 16'h0000, 8'h3C, 21'h180000));
    plan.push_back(read_row(16'h0000, 8'h3C));
    plan.push_back(access_row(MODE_WRITE, 16'h0000, 8'hFA, '0));
    plan.push_back(access_row(MODE_WRITE, 16'hBFFF, 8'hC3, '0));
    plan.push_back(read_row(16'hBFFF, 8'hC3));
    // disabled RAM drops writes and reads as open bus
    plan.push_back(access_row(MODE_WRITE, 16'h1FFF, 8'h0B, '0));
    plan.push_back(access_row(MODE_WRITE, 16'hBFFF, 8'h11, '0));
    plan.push_back(read_row(16'hBFFF, OPEN_BUS));
    plan.push_back(access_row(MODE_WRITE, 16'h1000, 8'h0A, '0));
    plan.push_back(read_row(16'hBFFF, 8'hC3));
    plan.push_back(access_row(MODE_WRITE, 16'h7FFF, 8'h00, '0));
    plan.push_back(read_row(16'hA000, 8'h00));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_idle();
        write_cfg(plan[i].cfg_idx, plan[i].cfg_val);
      end else begin
        issue(plan[i].req, plan[i].typed, plan[i].rd);
      end
    end

    base = n_reads + n_writes + n_loads + n_ignored;
    for (phase = 0; phase < N_PHASES; phase++) begin
      case (phase)
        0: begin
          rom_sz = 21;
          ram_sz = 15;
        end
        1: begin
          rom_sz = ROM_SIZE_RESET;
          ram_sz = 0;
        end
        2: begin
          rom_sz = 31;
          ram_sz = 1;
        end
        3: begin
          rom_sz = 18;
          ram_sz = 13;
        end
        default: begin
          rom_sz = $urandom_range(15, 21);
          ram_sz = $urandom_range(0, 15);
        end
      endcase
      wait_idle();
      write_cfg(CFG_ROM_SIZE, CFG_DATA_W'(rom_sz));
      write_cfg(CFG_RAM_SIZE, CFG_DATA_W'(ram_sz));
      while (n_reads + n_writes + n_loads + n_ignored - base < (phase + 1) * PHASE_ITEMS) begin
        it = random_access();
        // load the mapped ROM byte first so no read hits an unloaded entry
        if (it.mode == MODE_READ && !it.address[15] &&
            !rom_img.exists(rom_index(it.address))) begin
          fill            = it;
          fill.mode       = MODE_LOAD;
          fill.address    = 16'($urandom);
          fill.data       = 8'($urandom);
          fill.rom_offset = ROM_ADDR_BITS'(rom_index(it.address));
          issue(fill, 1'b0, 8'h00);
        end
        issue(it, 1'b0, 8'h00);
      end
    end

    wait_idle();
    $display("Covered %0d reads (%0d checked), %0d writes, %0d ROM loads, %0d dropped",
             n_reads, n_checked, n_writes, n_loads, n_ignored);
    $display("requests across %0d size settings; %0d mismatches", N_PHASES + 1, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule : mbc1_bank_controller_top_tb
